FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

FILE: design/tsched_pkg.sv
// Package with constants and codes of the task scheduler.
package tsched_pkg;
	localparam int MaxTasks = 64;
	localparam int IdW = $clog2(MaxTasks + 1);
	localparam int PtrW = $clog2(MaxTasks);
	localparam logic [2:0] OP_SPAWN = 3'd0;
	localparam logic [2:0] OP_POP = 3'd1;
	localparam logic [2:0] OP_SLEEP = 3'd2;
	localparam logic [2:0] OP_WAKE_T = 3'd3;
	localparam logic [2:0] OP_WAKE_H = 3'd4;
	localparam logic [2:0] OP_FINISH = 3'd5;
	localparam logic [2:0] OP_TICK = 3'd6;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_NOSPAWN = 2'd2;
	localparam logic [30:0] NoWakeWait = 31'd10000;
	localparam logic [30:0] WaitSat = 31'h7FFFFFFF;
	// Result of one scan pass over the task table.
	typedef struct packed {
		logic found;
		logic [IdW-1:0] id;
		logic [31:0] wtime;
	} scan_res_t;
endpackage

FILE: design/tsched_scan.sv
// Sequential minimum-wake-time search, one task entry per cycle.
module tsched_scan (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [tsched_pkg::IdW-1:0] last_id,
	input logic [31:0] now_ms,
	input logic expired_only,
	output logic [tsched_pkg::IdW-1:0] rd_id,
	input logic rd_sleeping,
	input logic [31:0] rd_wtime,
	output logic done,
	output tsched_pkg::scan_res_t res
);
	// The entry read at rd_id arrives in the next cycle (registered memory).
	logic run_q, chk_q;
	logic [tsched_pkg::IdW-1:0] idx_q, chk_id_q;
	logic [tsched_pkg::IdW-1:0] last_q;
	tsched_pkg::scan_res_t best_q;
	logic hit;
	assign rd_id = idx_q;
	assign hit = rd_sleeping && (!expired_only || rd_wtime <= now_ms) &&
		(!best_q.found || rd_wtime < best_q.wtime);
	assign res = best_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			chk_q <= 1'b0;
			done <= 1'b0;
			idx_q <= '0;
			chk_id_q <= '0;
			last_q <= '0;
			best_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				best_q <= '0;
				last_q <= last_id;
				idx_q <= tsched_pkg::IdW'(1);
				run_q <= (last_id != '0);
				chk_q <= 1'b0;
				done <= (last_id == '0);
			end else begin
				chk_q <= run_q;
				chk_id_q <= idx_q;
				if (run_q) begin
					if (idx_q == last_q) run_q <= 1'b0;
					else idx_q <= idx_q + 1'b1;
				end
				if (chk_q) begin
					if (hit) best_q <= '{found: 1'b1, id: chk_id_q, wtime: rd_wtime};
					if (!run_q) done <= 1'b1;
				end
			end
		end
	end
endmodule

FILE: design/task_ready_and_sleep_scheduler_top.sv
// Top level of the task scheduler: sequencer, task tables and ready list.
//  channel  | signals                                        | handshake
//  command  | operation task_req now_ms delay_ms             | start when !busy
//  result   | task_id status woke_by_timeout moved_count     | done strobe
//           | next_wait_ms                                   |
//  config   | task_limit_we task_limit                       | written when we
// Spawn, pop, wake, sleep and finish keep busy high through the link table read and
// write steps; a rejected or empty command goes straight to the finish state.
// A tick runs one scan of the task table for every task moved, one more that finds no
// expired task and one more for the next wait. The done strobe comes in the first
// cycle with busy low. Reset clears all control state; the link and wake time tables
// are only read where written. The result cannot be stalled.
module task_ready_and_sleep_scheduler_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] operation,
	input logic [6:0] task_req,
	input logic [31:0] now_ms,
	input logic [30:0] delay_ms,
	input logic task_limit_we,
	input logic [6:0] task_limit,
	output logic done,
	output logic [6:0] task_id,
	output logic [1:0] status,
	output logic woke_by_timeout,
	output logic [6:0] moved_count,
	output logic [30:0] next_wait_ms
);
	localparam int IW = tsched_pkg::IdW;
	localparam int MT = tsched_pkg::MaxTasks;
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_UNL = 4'd2;
	localparam logic [3:0] S_ACT = 4'd3;
	localparam logic [3:0] S_PUSH = 4'd4;
	localparam logic [3:0] S_SCAN = 4'd5;
	localparam logic [3:0] S_SWAIT = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;
	localparam logic [3:0] S_SPRD = 4'd8;

	logic [3:0] state_q;
	logic [2:0] op_q;
	logic [IW-1:0] req_q, t_q, cur_q, head_q, tail_q, made_q, limit_q;
	logic [31:0] now_q, wake_q;
	logic [IW-1:0] nxt_eff, prv_eff;
	logic [tsched_pkg::PtrW-1:0] idle_rd_q;
	logic [IW-1:0] idle_cnt_q;
	logic [MT:0] sleeping_q, tmark_q, queued_q, idlef_q;
	logic [IW-1:0] id_q;
	logic [1:0] st_q;
	logic woke_q;
	logic [IW-1:0] moved_q;
	logic [30:0] wait_q;
	logic final_q;

	// Link and wake tables, each written and read at one address a cycle.
	logic [IW-1:0] next_mem [MT+1];
	logic [IW-1:0] prev_mem [MT+1];
	logic [31:0] wake_mem [MT+1];
	logic [IW-1:0] ring_mem [MT];
	logic [IW-1:0] next_rd, prev_rd, ring_rd;
	logic [31:0] wake_rd;
	logic sleep_rd;
	logic [IW-1:0] link_addr, scan_addr;
	logic n_we, p_we, w_we, r_we;
	logic [IW-1:0] n_wa, n_wd, p_wa, p_wd;
	logic [tsched_pkg::PtrW-1:0] r_wa;

	logic scan_go, scan_done;
	tsched_pkg::scan_res_t scan_res;
	logic [IW-1:0] lim_eff;
	logic [32:0] wsum;
	logic [31:0] wait_diff;

	assign lim_eff = (limit_q > IW'(MT)) ? IW'(MT) : limit_q;
	assign wsum = {1'b0, now_ms} + {2'b0, delay_ms};
	assign busy = (state_q != S_IDLE);
	assign wait_diff = (scan_res.wtime > now_q) ? scan_res.wtime - now_q : 32'd0;

	always_ff @(posedge clk) begin
		if (n_we) next_mem[n_wa] <= n_wd;
		if (p_we) prev_mem[p_wa] <= p_wd;
		if (w_we) wake_mem[t_q] <= wake_q;
		if (r_we) ring_mem[r_wa] <= cur_q;
		next_rd <= next_mem[link_addr];
		prev_rd <= prev_mem[link_addr];
		wake_rd <= wake_mem[scan_addr];
		sleep_rd <= sleeping_q[scan_addr];
		ring_rd <= ring_mem[idle_rd_q];
	end

	tsched_scan u_scan (
		.clk(clk), .arst_n(arst_n), .go(scan_go), .last_id(made_q), .now_ms(now_q),
		.expired_only(!final_q), .rd_id(scan_addr), .rd_sleeping(sleep_rd),
		.rd_wtime(wake_rd), .done(scan_done), .res(scan_res)
	);

	assign link_addr = t_q;

	// The tail has no successor and the head no predecessor, whatever the table holds.
	assign nxt_eff = (t_q == tail_q) ? '0 : next_rd;
	assign prv_eff = (t_q == head_q) ? '0 : prev_rd;

	// Memory write ports driven from the sequencer state.
	always_comb begin
		n_we = 1'b0; n_wa = '0; n_wd = '0;
		p_we = 1'b0; p_wa = '0; p_wd = '0;
		w_we = 1'b0; r_we = 1'b0; r_wa = '0;
		case (state_q)
			S_UNL: begin
				// Unlink t using its prev/next read in the step before.
				if (queued_q[t_q]) begin
					if (prv_eff != '0) begin n_we = 1'b1; n_wa = prv_eff; n_wd = nxt_eff; end
					if (nxt_eff != '0) begin p_we = 1'b1; p_wa = nxt_eff; p_wd = prv_eff; end
				end
			end
			S_PUSH: begin
				if (op_q == tsched_pkg::OP_WAKE_H) begin
					n_we = 1'b1; n_wa = t_q; n_wd = head_q;
					p_we = 1'b1; p_wa = head_q; p_wd = t_q;
				end else begin
					n_we = 1'b1; n_wa = tail_q; n_wd = t_q;
					p_we = 1'b1; p_wa = t_q; p_wd = tail_q;
				end
			end
			S_ACT: begin
				if (op_q == tsched_pkg::OP_SLEEP) w_we = 1'b1;
				if (op_q == tsched_pkg::OP_FINISH && idle_cnt_q < IW'(MT)) begin
					r_we = 1'b1;
					r_wa = tsched_pkg::PtrW'({1'b0, idle_rd_q} + idle_cnt_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0; req_q <= '0; t_q <= '0; cur_q <= '0;
			head_q <= '0; tail_q <= '0; made_q <= '0; limit_q <= IW'(MT);
			now_q <= '0; wake_q <= '0;
			idle_rd_q <= '0; idle_cnt_q <= '0;
			sleeping_q <= '0; tmark_q <= '0; queued_q <= '0; idlef_q <= '0;
			id_q <= '0; st_q <= '0; woke_q <= 1'b0; moved_q <= '0; wait_q <= '0;
			final_q <= 1'b0; scan_go <= 1'b0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			scan_go <= 1'b0;
			if (task_limit_we) limit_q <= task_limit;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= operation; req_q <= task_req; now_q <= now_ms;
						id_q <= '0; st_q <= tsched_pkg::ST_OK; woke_q <= 1'b0;
						moved_q <= '0; wait_q <= '0; final_q <= 1'b0;
						wake_q <= wsum[32] ? 32'hFFFFFFFF : wsum[31:0];
						case (operation)
							tsched_pkg::OP_SPAWN: begin
								if (idle_cnt_q != '0) state_q <= S_SPRD;
								else if (made_q < lim_eff) begin
									made_q <= made_q + 1'b1;
									t_q <= made_q + 1'b1;
									id_q <= made_q + 1'b1;
									state_q <= S_ACT;
								end else begin
									st_q <= tsched_pkg::ST_NOSPAWN;
									state_q <= S_FIN;
								end
							end
							tsched_pkg::OP_POP: begin
								if (head_q == '0) begin
									st_q <= tsched_pkg::ST_EMPTY;
									state_q <= S_FIN;
								end else begin
									t_q <= head_q; id_q <= head_q;
									woke_q <= tmark_q[head_q];
									state_q <= S_RD;
								end
							end
							tsched_pkg::OP_SLEEP, tsched_pkg::OP_FINISH: begin
								t_q <= cur_q;
								state_q <= (cur_q != '0) ? S_RD : S_FIN;
							end
							tsched_pkg::OP_WAKE_T, tsched_pkg::OP_WAKE_H: begin
								t_q <= task_req;
								if (task_req != '0 && task_req <= made_q && !idlef_q[task_req])
									state_q <= S_RD;
								else state_q <= S_FIN;
							end
							tsched_pkg::OP_TICK: begin
								scan_go <= 1'b1;
								state_q <= S_SCAN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_SPRD: begin
					// Ring data became valid this cycle.
					t_q <= ring_rd; id_q <= ring_rd;
					idle_rd_q <= idle_rd_q + 1'b1;
					idle_cnt_q <= idle_cnt_q - 1'b1;
					idlef_q[ring_rd] <= 1'b0;
					state_q <= S_ACT;
				end
				S_RD: state_q <= S_UNL;
				S_UNL: begin
					// Link words read for t in S_RD are valid in this cycle.
					if (queued_q[t_q]) begin
						if (prv_eff == '0) head_q <= nxt_eff;
						if (nxt_eff == '0) tail_q <= prv_eff;
						queued_q[t_q] <= 1'b0;
					end
					state_q <= S_ACT;
				end
				S_ACT: begin
					state_q <= S_FIN;
					case (op_q)
						tsched_pkg::OP_SPAWN: begin
							sleeping_q[t_q] <= 1'b0; tmark_q[t_q] <= 1'b0;
							state_q <= S_PUSH;
						end
						tsched_pkg::OP_POP: begin
							cur_q <= t_q; tmark_q[t_q] <= 1'b0;
						end
						tsched_pkg::OP_SLEEP: begin
							sleeping_q[t_q] <= 1'b1; cur_q <= '0;
						end
						tsched_pkg::OP_FINISH: begin
							sleeping_q[t_q] <= 1'b0; tmark_q[t_q] <= 1'b0;
							if (idle_cnt_q < IW'(MT)) begin
								idle_cnt_q <= idle_cnt_q + 1'b1;
								idlef_q[t_q] <= 1'b1;
							end
							cur_q <= '0;
						end
						tsched_pkg::OP_WAKE_T, tsched_pkg::OP_WAKE_H: begin
							sleeping_q[t_q] <= 1'b0; tmark_q[t_q] <= 1'b0;
							state_q <= S_PUSH;
						end
						default: ;
					endcase
				end
				S_PUSH: begin
					queued_q[t_q] <= 1'b1;
					if (op_q == tsched_pkg::OP_WAKE_H) begin
						if (head_q == '0) tail_q <= t_q;
						head_q <= t_q;
					end else begin
						if (tail_q == '0) head_q <= t_q;
						tail_q <= t_q;
					end
					state_q <= (op_q == tsched_pkg::OP_TICK) ? S_SWAIT : S_FIN;
					if (op_q == tsched_pkg::OP_TICK) scan_go <= 1'b1;
				end
				S_SCAN: begin
					if (scan_done) begin
						if (final_q) begin
							if (!scan_res.found) wait_q <= tsched_pkg::NoWakeWait;
							else if (wait_diff[31]) wait_q <= tsched_pkg::WaitSat;
							else wait_q <= wait_diff[30:0];
							state_q <= S_FIN;
						end else if (scan_res.found) begin
							t_q <= scan_res.id;
							sleeping_q[scan_res.id] <= 1'b0;
							tmark_q[scan_res.id] <= 1'b1;
							moved_q <= moved_q + 1'b1;
							state_q <= S_PUSH;
						end else begin
							final_q <= 1'b1;
							scan_go <= 1'b1;
						end
					end
				end
				S_SWAIT: state_q <= S_SCAN;
				S_FIN: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign task_id = id_q;
	assign status = st_q;
	assign woke_by_timeout = woke_q;
	assign moved_count = moved_q;
	assign next_wait_ms = wait_q;
endmodule

FILE: design/tsched_checker.sv
// Port-level checker for the task scheduler, bound to the top level.
`include "assert_macros.svh"
module tsched_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [1:0] status,
	input logic [6:0] task_id,
	input logic woke_by_timeout
);
	`CHK_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted word did not raise busy")
	`CHK_IMPL(a_done_busy, clk, arst_n, done, !busy, "result strobe while still busy")
	`CHK_NEXT(a_done_once, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`CHK_IMPL(a_stat_id, clk, arst_n, done && status != tsched_pkg::ST_OK, task_id == 7'd0, "error result with id")
	`CHK_IMPL(a_woke_id, clk, arst_n, done && woke_by_timeout, task_id != 7'd0, "woke flag without id")
endmodule

bind task_ready_and_sleep_scheduler_top tsched_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .task_id(task_id), .woke_by_timeout(woke_by_timeout)
);
